/* hw/rtl/wtq_pkg.sv */
// Shared types and codes for the wrap-aware timer queue.
package wtq_pkg;

  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  localparam logic [1:0] KIND_EXPIRED = 2'd0;
  localparam logic [1:0] KIND_INSERT  = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;

  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_DROP   = 2'd2;
  localparam logic [1:0] CELL_UNWRAP = 2'd3;

  typedef struct packed {
    logic        mode;
    logic [7:0]  timer_id;
    logic [31:0] delay_ticks;
    logic [31:0] clock_now;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  expired_id;
    logic        forced;
    logic        queue_full;
    logic [31:0] wait_ticks;
    logic        queue_empty;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] op;
    logic       new_wrapped;
  } cell_ctrl_t;

endpackage

/* hw/rtl/wtq_cell.sv */
// Sorted chain slot: holds an entry, shifts right on insert, left on drop; clears wrap.
module wtq_cell #(
  parameter int CLOCK_BITS = 32,
  parameter int ID_BITS    = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  wtq_pkg::cell_ctrl_t    ctrl,
  input  logic [CLOCK_BITS-1:0]  new_deadline,
  input  logic [ID_BITS-1:0]     new_id,
  input  logic                   prev_after,
  input  logic                   prev_valid,
  input  logic                   prev_wrapped,
  input  logic [CLOCK_BITS-1:0]  prev_deadline,
  input  logic [ID_BITS-1:0]     prev_id,
  input  logic                   next_valid,
  input  logic                   next_wrapped,
  input  logic [CLOCK_BITS-1:0]  next_deadline,
  input  logic [ID_BITS-1:0]     next_id,
  output logic                   valid,
  output logic                   wrapped,
  output logic [CLOCK_BITS-1:0]  deadline,
  output logic [ID_BITS-1:0]     id,
  output logic                   after
);
  import wtq_pkg::*;

  // entry sorts strictly ahead of the new key, so it stays put
  assign after = valid && ((!wrapped && ctrl.new_wrapped) ||
                           ((wrapped == ctrl.new_wrapped) && (deadline < new_deadline)));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      wrapped <= 1'b0;
    end else begin
      case (ctrl.op)
        CELL_INSERT: begin
          if (!after) begin
            if (prev_after) begin
              valid    <= 1'b1;
              wrapped  <= ctrl.new_wrapped;
              deadline <= new_deadline;
              id       <= new_id;
            end else begin
              valid    <= prev_valid;
              wrapped  <= prev_wrapped;
              deadline <= prev_deadline;
              id       <= prev_id;
            end
          end
        end
        CELL_DROP: begin
          valid    <= next_valid;
          wrapped  <= next_wrapped;
          deadline <= next_deadline;
          id       <= next_id;
        end
        CELL_UNWRAP: wrapped <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

/* hw/rtl/wrap_aware_timer_queue.sv */
// Top level of the wrap-aware timer queue: sequencer, tick clock and the cell chain.
//
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_ready   | wtq_pkg::in_word_t  (insert or advance)
//  out     | output    | out_valid/out_ready | wtq_pkg::out_word_t (expiry, status, done)
//
// An insert, with out free, compares in every cell and shifts the chain unless it is full.
// An advance sets the tick clock; if the clock wrapped, it force-expires the unwrapped
// heads, then clears the wrap marks. The drain moves one head per cycle unless out stalls.
// Reset empties the chain and sets the tick clock to zero. A stalled out channel holds the
// sequencer; one input word is captured while the last result still waits.
module wrap_aware_timer_queue #(
  parameter int DEPTH      = 32,
  parameter int ID_BITS    = 8,
  parameter int CLOCK_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  wtq_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output wtq_pkg::out_word_t out_word
);
  import wtq_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_FORCE  = 2'd2;
  localparam logic [1:0] ST_EXPIRE = 2'd3;

  logic [1:0]            state, state_next;
  logic [CLOCK_BITS-1:0] cur_clock, cur_clock_next;

  logic                  item_mode;
  logic [ID_BITS-1:0]    item_id;
  logic [CLOCK_BITS-1:0] item_delay;
  logic [CLOCK_BITS-1:0] item_now;

  logic [ID_BITS+7:0]     id_ext;
  logic [CLOCK_BITS+31:0] delay_ext;
  logic [CLOCK_BITS+31:0] now_ext;

  cell_ctrl_t            ctrl;
  logic [CLOCK_BITS-1:0] new_deadline;

  logic [DEPTH-1:0]      c_valid, c_wrapped, c_after;
  logic [CLOCK_BITS-1:0] c_deadline [DEPTH];
  logic [ID_BITS-1:0]    c_id       [DEPTH];

  logic                  out_free, out_load;
  out_word_t             out_next;

  logic [CLOCK_BITS-1:0] head_diff;
  logic [CLOCK_BITS+31:0] diff_ext;
  logic [ID_BITS+7:0]    head_id_ext;
  logic                  head_due;

  assign id_ext    = {{ID_BITS{1'b0}}, in_word.timer_id};
  assign delay_ext = {{CLOCK_BITS{1'b0}}, in_word.delay_ticks};
  assign now_ext   = {{CLOCK_BITS{1'b0}}, in_word.clock_now};

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  assign new_deadline = cur_clock + item_delay;

  assign head_diff   = c_deadline[0] - cur_clock;
  assign diff_ext    = {32'd0, head_diff};
  assign head_id_ext = {8'd0, c_id[0]};
  assign head_due    = c_valid[0] && !c_wrapped[0] && (c_deadline[0] <= cur_clock);

  // chain of cells, head at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  p_after, p_valid, p_wrapped, n_valid, n_wrapped;
    logic [CLOCK_BITS-1:0] p_deadline, n_deadline;
    logic [ID_BITS-1:0]    p_id, n_id;

    if (i == 0) begin : g_first
      assign p_after    = 1'b1;
      assign p_valid    = 1'b0;
      assign p_wrapped  = 1'b0;
      assign p_deadline = '0;
      assign p_id       = '0;
    end else begin : g_mid
      assign p_after    = c_after[i-1];
      assign p_valid    = c_valid[i-1];
      assign p_wrapped  = c_wrapped[i-1];
      assign p_deadline = c_deadline[i-1];
      assign p_id       = c_id[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign n_valid    = 1'b0;
      assign n_wrapped  = 1'b0;
      assign n_deadline = '0;
      assign n_id       = '0;
    end else begin : g_body
      assign n_valid    = c_valid[i+1];
      assign n_wrapped  = c_wrapped[i+1];
      assign n_deadline = c_deadline[i+1];
      assign n_id       = c_id[i+1];
    end

    wtq_cell #(
      .CLOCK_BITS (CLOCK_BITS),
      .ID_BITS    (ID_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .ctrl          (ctrl),
      .new_deadline  (new_deadline),
      .new_id        (item_id),
      .prev_after    (p_after),
      .prev_valid    (p_valid),
      .prev_wrapped  (p_wrapped),
      .prev_deadline (p_deadline),
      .prev_id       (p_id),
      .next_valid    (n_valid),
      .next_wrapped  (n_wrapped),
      .next_deadline (n_deadline),
      .next_id       (n_id),
      .valid         (c_valid[i]),
      .wrapped       (c_wrapped[i]),
      .deadline      (c_deadline[i]),
      .id            (c_id[i]),
      .after         (c_after[i])
    );
  end

  always_comb begin
    state_next       = state;
    cur_clock_next   = cur_clock;
    ctrl.op          = CELL_HOLD;
    ctrl.new_wrapped = (new_deadline < cur_clock);
    out_load         = 1'b0;
    out_next         = '0;
    out_next.kind    = KIND_EXPIRED;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (item_mode == MODE_ADVANCE) begin
          cur_clock_next = item_now;
          state_next     = (item_now < cur_clock) ? ST_FORCE : ST_EXPIRE;
        end else if (out_free) begin
          out_load        = 1'b1;
          out_next.kind   = KIND_INSERT;
          out_next.last   = 1'b1;
          // a full chain drops the insert
          if (c_valid[DEPTH-1]) out_next.queue_full = 1'b1;
          else                  ctrl.op = CELL_INSERT;
          state_next = ST_IDLE;
        end
      end
      ST_FORCE: begin
        if (c_valid[0] && !c_wrapped[0]) begin
          if (out_free) begin
            out_load             = 1'b1;
            out_next.kind        = KIND_EXPIRED;
            out_next.expired_id  = head_id_ext[7:0];
            out_next.forced      = 1'b1;
            out_next.queue_empty = !c_valid[1];
            ctrl.op              = CELL_DROP;
          end
        end else begin
          // only wrapped entries remain; they now live in the current epoch
          ctrl.op    = CELL_UNWRAP;
          state_next = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        if (out_free) begin
          out_load = 1'b1;
          if (head_due) begin
            out_next.kind        = KIND_EXPIRED;
            out_next.expired_id  = head_id_ext[7:0];
            out_next.queue_empty = !c_valid[1];
            ctrl.op              = CELL_DROP;
          end else begin
            out_next.kind        = KIND_DONE;
            out_next.last        = 1'b1;
            out_next.queue_empty = !c_valid[0];
            if (c_valid[0]) begin
              out_next.wait_ticks = (|diff_ext[CLOCK_BITS+31:32]) ? 32'hFFFF_FFFF
                                                                 : diff_ext[31:0];
            end
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_clock <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_clock <= cur_clock_next;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_mode  <= in_word.mode;
      item_id    <= id_ext[ID_BITS-1:0];
      item_delay <= delay_ext[CLOCK_BITS-1:0];
      item_now   <= now_ext[CLOCK_BITS-1:0];
    end
    if (out_load) out_word <= out_next;
  end

`ifndef SYNTH
  // occupied cells form an unbroken run from the head
  a_contiguous: assert property (@(posedge clk) disable iff (rst)
    (c_valid[DEPTH-1:1] & ~c_valid[DEPTH-2:0]) == '0)
    else $error("timer chain has a gap");

  // the two front cells stay in key order
  a_head_order: assert property (@(posedge clk) disable iff (rst)
    c_valid[1] |-> ((!c_wrapped[0] && c_wrapped[1]) ||
                    ((c_wrapped[0] == c_wrapped[1]) && (c_deadline[0] <= c_deadline[1]))))
    else $error("timer chain out of order at head");

  // a dropped insert leaves the chain occupancy unchanged
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC && item_mode == MODE_INSERT && out_free && c_valid[DEPTH-1])
    |=> (c_valid == $past(c_valid)))
    else $error("full-queue insert changed the chain");
`endif

endmodule

/* dv/tb_wrap_aware_timer_queue.sv */
`timescale 1ns / 1ps
// Testbench for the wrap-aware timer queue: timer-list scoreboard, word drivers and top.

import wtq_pkg::*;

localparam int QDEPTH = 32;

// Mirrors the sorted timer list and holds the result words it should produce.
class timer_sb;
  logic [31:0] slot_deadline [QDEPTH];
  logic [7:0]  slot_id [QDEPTH];
  bit          slot_wrapped [QDEPTH];
  int          count;
  logic [31:0] tick_now;
  out_word_t   pending_results [$];
  int errors, n_checked;
  int n_insert, n_dropped, n_advance, n_wraps, n_expired, n_forced;

  function new();
    count = 0;
    tick_now = '0;
  endfunction

  function void queue_result(logic [1:0] kind, logic [7:0] id, bit forced, bit full,
                             logic [31:0] wait_t, bit last);
    out_word_t r;
    r.kind        = kind;
    r.expired_id  = id;
    r.forced      = forced;
    r.queue_full  = full;
    r.wait_ticks  = wait_t;
    r.queue_empty = (count == 0);
    r.last        = last;
    pending_results.push_back(r);
  endfunction

  function void expire_head(bit forced);
    logic [7:0] id;
    id = slot_id[0];
    for (int i = 0; i < count - 1; i++) begin
      slot_deadline[i] = slot_deadline[i + 1];
      slot_id[i]       = slot_id[i + 1];
      slot_wrapped[i]  = slot_wrapped[i + 1];
    end
    count--;
    n_expired++;
    if (forced) n_forced++;
    queue_result(KIND_EXPIRED, id, forced, 1'b0, '0, 1'b0);
  endfunction

  // order key is (wrapped, deadline)
  function bit sorts_before(bit wa, logic [31:0] da, bit wb, logic [31:0] db);
    if (wa != wb) return !wa;
    return da < db;
  endfunction

  function void note_word(in_word_t w);
    logic [31:0] dl;
    logic [31:0] wait_t;
    bit wr;
    int pos;
    if (w.mode == MODE_INSERT) begin
      n_insert++;
      if (count >= QDEPTH) begin
        n_dropped++;
        queue_result(KIND_INSERT, '0, 1'b0, 1'b1, '0, 1'b1);
        return;
      end
      dl = tick_now + w.delay_ticks;
      wr = dl < tick_now;
      pos = 0;
      // new timer lands ahead of any equal key
      while (pos < count && sorts_before(slot_wrapped[pos], slot_deadline[pos], wr, dl))
        pos++;
      for (int i = count; i > pos; i--) begin
        slot_deadline[i] = slot_deadline[i - 1];
        slot_id[i]       = slot_id[i - 1];
        slot_wrapped[i]  = slot_wrapped[i - 1];
      end
      slot_deadline[pos] = dl;
      slot_id[pos]       = w.timer_id;
      slot_wrapped[pos]  = wr;
      count++;
      queue_result(KIND_INSERT, '0, 1'b0, 1'b0, '0, 1'b1);
    end else begin
      n_advance++;
      if (w.clock_now < tick_now) begin
        n_wraps++;
        while (count > 0 && !slot_wrapped[0]) expire_head(1'b1);
        for (int i = 0; i < count; i++) slot_wrapped[i] = 1'b0;
      end
      tick_now = w.clock_now;
      while (count > 0 && !slot_wrapped[0] && slot_deadline[0] <= tick_now)
        expire_head(1'b0);
      wait_t = (count > 0) ? slot_deadline[0] - tick_now : 32'd0;
      queue_result(KIND_DONE, '0, 1'b0, 1'b0, wait_t, 1'b1);
    end
  endfunction

  function void field_ok(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_word(out_word_t got);
    out_word_t want;
    if (pending_results.size() == 0) begin
      errors++;
      $display("%0t: result word with nothing expected: expected none, actual %h",
               $time, got);
      return;
    end
    want = pending_results.pop_front();
    n_checked++;
    field_ok("kind", 32'(want.kind), 32'(got.kind));
    field_ok("expired_id", 32'(want.expired_id), 32'(got.expired_id));
    field_ok("forced", 32'(want.forced), 32'(got.forced));
    field_ok("queue_full", 32'(want.queue_full), 32'(got.queue_full));
    field_ok("wait_ticks", want.wait_ticks, got.wait_ticks);
    field_ok("queue_empty", 32'(want.queue_empty), 32'(got.queue_empty));
    field_ok("last", 32'(want.last), 32'(got.last));
  endfunction
endclass

module tb_wrap_aware_timer_queue;
  localparam int LONG_HOLD    = 150;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 40;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_word;

  timer_sb     sb;
  bit          calm;
  bit          hold_req;
  int          stall_cycles;
  logic [31:0] plan_clock;

  wrap_aware_timer_queue uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // result side: short random stalls, one long hold on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) sb.check_word(out_word);
      if (in_valid && in_ready) sb.note_word(in_word);
      if ((out_valid && out_ready) || (in_valid && in_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_word(in_word_t w);
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_insert(logic [7:0] id, logic [31:0] delay);
    in_word_t w;
    w.mode        = MODE_INSERT;
    w.timer_id    = id;
    w.delay_ticks = delay;
    w.clock_now   = $urandom;
    send_word(w);
  endtask

  task automatic send_advance(logic [31:0] now);
    in_word_t w;
    w.mode        = MODE_ADVANCE;
    w.timer_id    = 8'($urandom);
    w.delay_ticks = $urandom;
    w.clock_now   = now;
    plan_clock    = now;
    send_word(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_delay();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: return 32'hFFFF_FFFF - $urandom_range(0, 3000);
      default: return $urandom_range(0, 2500);
    endcase
  endfunction

  function automatic logic [31:0] pick_advance();
    case ($urandom_range(0, 19))
      0, 1: return $urandom;
      2, 3: return plan_clock - $urandom_range(1, 5000);  // mostly a wrap
      4, 5: return plan_clock;
      default: return plan_clock + $urandom_range(0, 700);
    endcase
  endfunction

  task automatic random_items(int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 55) send_insert(8'($urandom_range(0, 255)), pick_delay());
      else send_advance(pick_advance());
    end
  endtask

  initial begin
    int fill_n;
    sb         = new();
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_word    = '0;
    plan_clock = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: empty queue, zero and max delays, equal keys, wrap handling
    send_advance(32'h0000_0000);
    send_insert(8'h00, 32'h0000_0000);
    send_insert(8'hFF, 32'hFFFF_FFFF);
    send_insert(8'h55, 32'd100);
    send_insert(8'hAA, 32'd100);
    send_advance(32'h0000_0000);
    send_advance(32'd100);
    send_advance(32'hFFFF_FFF0);
    send_insert(8'h01, 32'h0000_0020);
    send_insert(8'h02, 32'hFFFF_FFFF);
    send_insert(8'h03, 32'd5);
    send_advance(32'hFFFF_FFFE);
    send_advance(32'h0000_0008);  // wrap: forced expiry of the unwrapped head
    send_advance(32'hFFFF_FFFF);
    send_advance(32'h0000_0000);  // wrap with nothing queued
    send_insert(8'hF0, 32'h8000_0000);
    send_advance(32'h7FFF_FFFF);
    send_advance(32'h8000_0000);

    random_items(45);

    // long hold on the result side while words keep coming
    hold_req = 1'b1;
    repeat (20) send_insert(8'($urandom_range(0, 255)), $urandom_range(0, 4000));
    wait_drained();

    // fill to capacity, overflow, then wrap with every slot unwrapped
    send_advance(32'h7000_0000 + $urandom_range(0, 4095));
    wait_drained();
    fill_n = QDEPTH - sb.count + 3;
    repeat (fill_n) send_insert(8'($urandom_range(0, 255)), $urandom_range(1, 5000));
    send_advance($urandom_range(0, 32'h0FFF_FFFF));
    wait_drained();

    random_items(35);
    calm = 1'b1;
    random_items(25);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d inserts (%0d dropped when full), %0d advances (%0d clock wraps)",
             sb.n_insert, sb.n_dropped, sb.n_advance, sb.n_wraps);
    $display("%0d expiries (%0d forced by wrap), %0d result words checked",
             sb.n_expired, sb.n_forced, sb.n_checked);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/wtq_pkg.sv
hw/rtl/wtq_cell.sv
hw/rtl/wrap_aware_timer_queue.sv
dv/tb_wrap_aware_timer_queue.sv
